[rtl/go_back_n_sender_assert.svh]
// Assertion macros for the Go-Back-N sender.
// Included by the top level; relies on aclk and aresetn in scope.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gbn_pkg.sv]
// Shared types, codes and payload helpers for the Go-Back-N sender.
// No dependencies.
package gbn_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int PAY_W         = PAYLOAD_BYTES * 8;
    localparam int SEQ_W         = 31;

    // item kinds on the input channel
    localparam logic [1:0] FUNC_MSG  = 2'd0;
    localparam logic [1:0] FUNC_ACK  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_ACK_CHK,
        ST_ACK_TMR,
        ST_LOOP,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic prep;
        logic msg_store;
        logic ack_move;
        logic dl_rd;
        logic ack_timer;
        logic loop_allowed;
        logic tick;
        logic send_rd;
        logic refuse;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       ack_ok;
        logic       base_eq_next;
        logic       cnt_zero;
        logic       last;
    } sts_t;

    // zero every byte from the first zero byte on
    function automatic logic [PAY_W-1:0] trim_payload(input logic [PAY_W-1:0] p);
        logic [PAY_W-1:0] r;
        logic             ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (p[8*i +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[8*i +: 8] = p[8*i +: 8];
        end
        return r;
    endfunction

    // signed sum of the bytes; trimmed bytes are zero and add nothing
    function automatic logic [31:0] byte_sum(input logic [PAY_W-1:0] p);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            s = s + {{24{p[8*i+7]}}, p[8*i +: 8]};
        end
        return s;
    endfunction

endpackage

[rtl/go_back_n_sender.sv]
// Top level of the Go-Back-N sender: controller plus datapath.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp and go_back_n_sender_assert.svh.
//
// channel  direction  handshake            contents
// s_       in         s_tvalid/s_tready    tuser func; tdata payload and ack header
// m_       out        m_tvalid/m_tready    tuser kind; tlast last; tdata packet
// cfg_     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One item at a time: accept, trim, decode, then per result a store read
// plus the output state, held until m_tready.
// An ack that moves base under outstanding packets adds a deadline read.
// aresetn is synchronous, active low; no clearing pass, the store starts unwritten.
// The output holds while m_tready is low; no new item is taken until done.
module go_back_n_sender #(
    parameter int BUFFER_ENTRIES = 64,
    parameter int WINDOW_MAX     = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // func
    // data_low, data_mid, data_high, ack_seq, ack_number, ack_sum
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,   // kind
    output logic         m_tlast,
    // seq_out, sum_out, out_low, out_mid, out_high, one zero pad bit
    output logic [223:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import gbn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbn_dp #(
        .BUFFER_ENTRIES (BUFFER_ENTRIES),
        .WINDOW_MAX     (WINDOW_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`include "go_back_n_sender_assert.svh"

    // input and output never open together
    `GBN_ASSERT_NOW(a_one_side, m_tvalid, !s_tready, "input taken while a result is pending")
    // refusal is a single all-zero result
    `GBN_ASSERT_NOW(a_refuse_zero, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "bad refusal")
    // an accepted item closes the input until it is done
    `GBN_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input stayed open after accept")

endmodule

[rtl/gbn_ctrl.sv]
// Controller state machine for the Go-Back-N sender.
// Depends on gbn_pkg; drives the datapath through cmd_t, reads sts_t.
module gbn_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  gbn_pkg::sts_t sts,
    output gbn_pkg::cmd_t cmd
);
    import gbn_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (sts.func)
                    FUNC_MSG: begin
                        if (sts.full) begin
                            cmd.refuse = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            cmd.msg_store = 1'b1;
                            state_next    = ST_LOOP;
                        end
                    end
                    FUNC_ACK: begin
                        if (sts.ack_ok) begin
                            cmd.ack_move = 1'b1;
                            state_next   = ST_ACK_CHK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_TICK: begin
                        cmd.tick   = 1'b1;
                        state_next = ST_LOOP;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ACK_CHK: begin
                if (sts.base_eq_next) begin
                    cmd.loop_allowed = 1'b1;
                    state_next       = ST_LOOP;
                end else begin
                    cmd.dl_rd  = 1'b1;
                    state_next = ST_ACK_TMR;
                end
            end
            ST_ACK_TMR: begin
                cmd.ack_timer    = 1'b1;
                cmd.loop_allowed = 1'b1;
                state_next       = ST_LOOP;
            end
            ST_LOOP: begin
                if (sts.cnt_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.send_rd = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = sts.last ? ST_IDLE : ST_LOOP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/gbn_dp.sv]
// Datapath of the Go-Back-N sender: sequence state, timer, packet store.
// Depends on gbn_pkg; steered by gbn_ctrl.
module gbn_dp #(
    parameter int BUFFER_ENTRIES = 64,
    parameter int WINDOW_MAX     = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                s_tuser,
    input  logic [255:0]              s_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast,
    output logic [223:0]              m_tdata,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  gbn_pkg::cmd_t             cmd,
    output gbn_pkg::sts_t             sts
);
    import gbn_pkg::*;

    localparam int SLOT_W = $clog2(BUFFER_ENTRIES);
    localparam int CNT_W  = $clog2(BUFFER_ENTRIES + 1);
    localparam int ENT_W  = PAY_W + 32;

    // configuration
    logic [5:0]  win_reg;
    logic [15:0] tmo_reg;

    // input item and trimmed payload
    logic [1:0]       func_reg;
    logic [PAY_W-1:0] pay_reg, tpay_reg;
    logic [31:0]      aseq_reg, anum_reg, asum_reg, bsum_reg;

    // protocol state
    logic [31:0]       now_reg, tleft_reg;
    logic              trun_reg;
    logic [SEQ_W-1:0]  base_reg, next_reg, end_reg, ptr_reg, seq_reg;
    logic [SLOT_W-1:0] bslot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              adv_reg, last_reg, kind_reg;

    // memories
    logic [ENT_W-1:0] pkt_mem [BUFFER_ENTRIES];
    logic [31:0]      dl_mem  [BUFFER_ENTRIES];
    logic [ENT_W-1:0] pkt_rd_reg;
    logic [31:0]      dl_rd_reg;

    // derived values
    logic [6:0]        eff_win;
    logic [31:0]       eff_to;
    logic [SEQ_W-1:0]  inflight, stored, ahead, wrem, allowed, ack_h, ack_d;
    logic              win_open;
    logic [31:0]       ack_sum, gap;
    logic [SLOT_W-1:0] ptr_slot, end_slot, new_bslot;
    logic [SLOT_W:0]   bsum_w;

    // slot of a sequence number that lies less than BUFFER_ENTRIES past base
    function automatic logic [SLOT_W-1:0] slot_of(
        input logic [SEQ_W-1:0]  s,
        input logic [SEQ_W-1:0]  b,
        input logic [SLOT_W-1:0] bs
    );
        logic [SEQ_W-1:0] d;
        logic [SLOT_W:0]  t;
        d = s - b;
        t = {1'b0, bs} + {1'b0, d[SLOT_W-1:0]};
        if (t >= (SLOT_W+1)'(BUFFER_ENTRIES)) t = t - (SLOT_W+1)'(BUFFER_ENTRIES);
        return t[SLOT_W-1:0];
    endfunction

    always_comb begin
        if (win_reg == 6'd0)                  eff_win = 7'd1;
        else if ({1'b0, win_reg} > 7'(WINDOW_MAX)) eff_win = 7'(WINDOW_MAX);
        else                                  eff_win = {1'b0, win_reg};
        eff_to   = (tmo_reg == 16'd0) ? 32'd1 : {16'd0, tmo_reg};
        inflight = next_reg - base_reg;
        stored   = end_reg - base_reg;
        ahead    = end_reg - next_reg;
        win_open = inflight < SEQ_W'(eff_win);
        wrem     = SEQ_W'(eff_win) - inflight;
        allowed  = !win_open ? '0 : ((wrem < ahead) ? wrem : ahead);
        ack_h    = anum_reg[SEQ_W-1:0] + 1'b1;
        ack_d    = ack_h - base_reg;
        ack_sum  = aseq_reg + anum_reg + bsum_reg;
        bsum_w   = {1'b0, bslot_reg} + {1'b0, ack_d[SLOT_W-1:0]};
        if (bsum_w >= (SLOT_W+1)'(BUFFER_ENTRIES))
            bsum_w = bsum_w - (SLOT_W+1)'(BUFFER_ENTRIES);
        new_bslot = bsum_w[SLOT_W-1:0];
        ptr_slot  = slot_of(ptr_reg, base_reg, bslot_reg);
        end_slot  = slot_of(end_reg, base_reg, bslot_reg);
        gap       = dl_rd_reg - now_reg;
        if (gap == 32'd0 || gap[31]) gap = 32'd1;
    end

    assign sts.func         = func_reg;
    assign sts.full         = stored >= SEQ_W'(BUFFER_ENTRIES);
    assign sts.ack_ok       = (ack_sum == asum_reg) && (ack_d <= inflight);
    assign sts.base_eq_next = base_reg == next_reg;
    assign sts.cnt_zero     = cnt_reg == '0;
    assign sts.last         = last_reg;

    // packet store: written by a message, read by each send
    always_ff @(posedge aclk) begin
        if (cmd.msg_store) begin
            pkt_mem[end_slot] <= {tpay_reg, {end_reg, 1'b0} + bsum_reg};
        end
        if (cmd.send_rd) begin
            pkt_rd_reg <= pkt_mem[ptr_slot];
        end
    end

    // deadline store: written by each send, read after an ack
    always_ff @(posedge aclk) begin
        if (cmd.send_rd) begin
            dl_mem[ptr_slot] <= now_reg + eff_to;
        end
        if (cmd.dl_rd) begin
            dl_rd_reg <= dl_mem[bslot_reg];
        end
    end

    // input capture and payload trim; no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= s_tuser;
            pay_reg  <= s_tdata[PAY_W-1:0];
            aseq_reg <= s_tdata[191:160];
            anum_reg <= s_tdata[223:192];
            asum_reg <= s_tdata[255:224];
        end
        if (cmd.prep) begin
            tpay_reg <= trim_payload(pay_reg);
            bsum_reg <= byte_sum(trim_payload(pay_reg));
        end
        if (cmd.send_rd) begin
            seq_reg <= ptr_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= 6'd8;
            tmo_reg   <= 16'd100;
            now_reg   <= '0;
            tleft_reg <= '0;
            trun_reg  <= 1'b0;
            base_reg  <= '0;
            next_reg  <= '0;
            end_reg   <= '0;
            bslot_reg <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            adv_reg   <= 1'b0;
            last_reg  <= 1'b0;
            kind_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_WINDOW:  win_reg <= cfg_data[5:0];
                    CFG_TIMEOUT: tmo_reg <= cfg_data;
                    default: ;
                endcase
            end
            // new message: buffer it, send at most one
            if (cmd.msg_store) begin
                end_reg <= end_reg + 1'b1;
                ptr_reg <= next_reg;
                adv_reg <= 1'b1;
                cnt_reg <= win_open ? CNT_W'(1) : '0;
                if (win_open && base_reg == next_reg) begin
                    trun_reg  <= 1'b1;
                    tleft_reg <= eff_to;
                end
            end
            // valid ack: move base and restart or stop the timer
            if (cmd.ack_move) begin
                base_reg  <= ack_h;
                bslot_reg <= new_bslot;
                if (ack_h == next_reg) begin
                    trun_reg <= end_reg != ack_h;
                    if (end_reg != ack_h) tleft_reg <= eff_to;
                end
            end
            if (cmd.ack_timer) begin
                trun_reg  <= 1'b1;
                tleft_reg <= gap;
            end
            if (cmd.loop_allowed) begin
                ptr_reg <= next_reg;
                adv_reg <= 1'b1;
                cnt_reg <= CNT_W'(allowed);
            end
            // tick: advance time, resend all on expiry
            if (cmd.tick) begin
                now_reg <= now_reg + 1'b1;
                ptr_reg <= base_reg;
                adv_reg <= 1'b0;
                if (trun_reg && tleft_reg <= 32'd1) begin
                    tleft_reg <= eff_to;
                    cnt_reg   <= CNT_W'(inflight);
                end else begin
                    cnt_reg <= '0;
                    if (trun_reg) tleft_reg <= tleft_reg - 1'b1;
                end
            end
            // one packet out of the store
            if (cmd.send_rd) begin
                ptr_reg  <= ptr_reg + 1'b1;
                cnt_reg  <= cnt_reg - 1'b1;
                last_reg <= cnt_reg == CNT_W'(1);
                kind_reg <= 1'b0;
                if (adv_reg) next_reg <= next_reg + 1'b1;
            end
            if (cmd.refuse) begin
                kind_reg <= 1'b1;
                last_reg <= 1'b1;
            end
        end
    end

    // result fields; a refusal carries zeros
    assign m_tuser = kind_reg;
    assign m_tlast = last_reg;
    assign m_tdata = kind_reg ? '0 :
        {1'b0, pkt_rd_reg[ENT_W-1:32], pkt_rd_reg[31:0], seq_reg};

endmodule

[tb/go_back_n_sender_tb.sv]
// Self-checking testbench for the Go-Back-N sender.
// Needs gbn_pkg and the go_back_n_sender RTL; drives messages, acks and ticks.
`timescale 1ns / 1ps

module go_back_n_sender_tb;
    import gbn_pkg::*;

    localparam int SLOTS       = 64;
    localparam int WIN_CAP     = 32;
    localparam int DRAIN_WAIT  = 100;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic         kind;
        logic [30:0]  seq;
        logic [31:0]  sum;
        logic [159:0] pay;
        logic         last;
    } packet_t;

    typedef struct {
        logic [1:0]   func;
        logic [159:0] pay;
        logic [31:0]  aseq;
        logic [31:0]  anum;
        logic [31:0]  asum;
        bit           good_sum;  // fill asum with the matching checksum
        int           n_out;     // expected result count, -1 = predictor only
    } dir_row_t;

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [1:0]   s_tuser;
    logic [255:0] s_tdata;
    logic         m_tvalid, m_tready, m_tuser, m_tlast;
    logic [223:0] m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    go_back_n_sender dut (.*);

    // sender state mirror
    logic [31:0]  g_now, g_tail, g_tleft;
    logic [30:0]  g_base, g_next;
    int           g_bslot;
    bit           g_trun;
    logic [5:0]   g_win;
    logic [15:0]  g_tmo;
    logic [159:0] slot_pay [SLOTS];
    logic [31:0]  slot_sum [SLOTS];
    logic [31:0]  slot_dl  [SLOTS];

    packet_t pending_pkts [$];
    packet_t item_pkts [$];
    int      n_errors, n_items, n_pkts, n_refused, n_resent;
    bit      idle_on;
    int      quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report(input string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // trimmed payload and signed sum of the bytes before the first zero
    function automatic logic [159:0] trim_bytes(input logic [159:0] p,
                                                output logic [31:0] s);
        logic [159:0] r;
        bit           ended;
        r = '0; s = '0; ended = 0;
        for (int i = 0; i < 20; i++) begin
            if (p[8*i +: 8] == 8'd0) ended = 1;
            if (!ended) begin
                r[8*i +: 8] = p[8*i +: 8];
                s = s + {{24{p[8*i+7]}}, p[8*i +: 8]};
            end
        end
        return r;
    endfunction

    function automatic int win_eff();
        int w;
        w = g_win;
        if (w < 1) w = 1;
        if (w > WIN_CAP) w = WIN_CAP;
        return w;
    endfunction

    function automatic logic [31:0] tmo_eff();
        return (g_tmo == 0) ? 32'd1 : {16'd0, g_tmo};
    endfunction

    function automatic int slot_at(input logic [30:0] s);
        logic [30:0] d;
        d = s - g_base;
        return (g_bslot + int'(d[5:0])) % SLOTS;
    endfunction

    function automatic void push_pkt(input logic [30:0] s);
        int      k;
        packet_t p;
        k = slot_at(s);
        slot_dl[k] = g_now + tmo_eff();
        p.kind = 1'b0; p.seq = s; p.sum = slot_sum[k]; p.pay = slot_pay[k]; p.last = 1'b0;
        item_pkts.push_back(p);
    endfunction

    function automatic void push_allowed();
        logic [30:0] after_tail;
        after_tail = g_tail[30:0] + 31'd1;
        while (int'(31'(g_next - g_base)) < win_eff() && after_tail != g_next) begin
            push_pkt(g_next);
            g_next = g_next + 31'd1;
        end
    endfunction

    // advance the mirror by one accepted item; returns the number of packets
    function automatic int predict_item(input logic [1:0] func, input logic [255:0] d);
        logic [159:0] tp;
        logic [31:0]  bsum, sum, gap;
        logic [30:0]  after_tail, h, adv_d;
        int           k, n;
        packet_t      p;
        item_pkts.delete();
        after_tail = g_tail[30:0] + 31'd1;
        tp = trim_bytes(d[159:0], bsum);
        case (func)
            FUNC_MSG: begin
                if (31'(after_tail - g_base) >= 31'(SLOTS)) begin
                    p.kind = 1'b1; p.seq = '0; p.sum = '0; p.pay = '0; p.last = 1'b0;
                    item_pkts.push_back(p);
                    n_refused++;
                end else begin
                    k = slot_at(after_tail);
                    slot_pay[k] = tp;
                    slot_sum[k] = {1'b0, after_tail} + {1'b0, after_tail} + bsum;
                    g_tail = {1'b0, after_tail};
                    if (int'(31'(g_next - g_base)) < win_eff() &&
                        g_next != after_tail + 31'd1) begin
                        if (g_base == g_next) begin
                            g_trun = 1; g_tleft = tmo_eff();
                        end
                        push_pkt(g_next);
                        g_next = g_next + 31'd1;
                    end
                end
            end
            FUNC_ACK: begin
                sum   = d[191:160] + d[223:192] + bsum;
                h     = d[222:192] + 31'd1;
                adv_d = h - g_base;
                if (sum == d[255:224] && adv_d <= 31'(g_next - g_base)) begin
                    g_bslot = (g_bslot + int'(adv_d[5:0])) % SLOTS;
                    g_base  = h;
                    if (g_base == g_next) begin
                        g_trun = 0;
                        if (after_tail != g_base) begin
                            g_trun = 1; g_tleft = tmo_eff();
                        end
                    end else begin
                        gap = slot_dl[slot_at(g_base)] - g_now;
                        if (gap == 0 || gap[31]) gap = 32'd1;
                        g_trun = 1; g_tleft = gap;
                    end
                    push_allowed();
                end
            end
            FUNC_TICK: begin
                g_now = g_now + 1;
                if (g_trun) begin
                    if (g_tleft <= 1) begin
                        g_tleft = tmo_eff();
                        for (logic [30:0] s = g_base; s != g_next; s = s + 31'd1) begin
                            push_pkt(s);
                            n_resent++;
                        end
                    end else begin
                        g_tleft = g_tleft - 1;
                    end
                end
            end
            default: ;
        endcase
        n = item_pkts.size();
        if (n > 0) item_pkts[n-1].last = 1'b1;
        foreach (item_pkts[i]) pending_pkts.push_back(item_pkts[i]);
        return n;
    endfunction

    // drive one input item and wait for its acceptance
    task automatic send_item(input logic [1:0] func, input logic [159:0] pay,
                             input logic [31:0] aseq, input logic [31:0] anum,
                             input logic [31:0] asum, output int n);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tuser  <= func;
        s_tdata  <= {asum, anum, aseq, pay};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n = predict_item(func, {asum, anum, aseq, pay});
        n_items++;
    endtask

    task automatic drain_out();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_pkts.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_out();
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_WINDOW) g_win = val[5:0];
        else if (idx == CFG_TIMEOUT) g_tmo = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [159:0] rand_payload();
        logic [159:0] p;
        if ($urandom_range(0, 5) == 0) begin
            p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        end else begin
            for (int i = 0; i < 20; i++)
                p[8*i +: 8] = ($urandom_range(0, 24) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        end
        return p;
    endfunction

    // ack with the matching checksum, or one that is off by one when spoil is set
    task automatic send_ack(input logic [31:0] anum, input bit spoil, output int n);
        logic [159:0] p;
        logic [31:0]  aseq, bs;
        p    = rand_payload();
        aseq = $urandom();
        void'(trim_bytes(p, bs));
        send_item(FUNC_ACK, p, aseq, anum, aseq + anum + bs + (spoil ? 32'd1 : 32'd0), n);
    endtask

    // random traffic, mostly well-formed against the mirror state
    task automatic random_traffic(input int count, input int msg_pct);
        int          r, n;
        logic [30:0] span;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < msg_pct) begin
                send_item(FUNC_MSG, rand_payload(), $urandom(), $urandom(), $urandom(), n);
            end else if (r < msg_pct + 30) begin
                span = g_next - g_base;
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_ack({1'b0, g_base + 31'($urandom_range(0, span))} - 32'd1, 0, n);
                else if (r == 6) send_ack($urandom(), 0, n);
                else if (r == 7) send_ack({1'b0, g_base} - 32'd1, 1, n);
                else if (r == 8)
                    send_item(FUNC_ACK, rand_payload(), $urandom(), $urandom(), $urandom(), n);
                else send_ack({1'b0, g_base} - 32'd1, 0, n);
            end else if (r < 97) begin
                send_item(FUNC_TICK, rand_payload(), $urandom(), $urandom(), $urandom(), n);
            end else begin
                send_item(FUNC_NONE, rand_payload(), $urandom(), $urandom(), $urandom(), n);
            end
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            packet_t e;
            n_pkts++;
            if (pending_pkts.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = pending_pkts.pop_front();
                if (m_tuser !== e.kind)
                    report($sformatf("kind %0b, want %0b", m_tuser, e.kind));
                if (m_tdata[30:0] !== e.seq)
                    report($sformatf("seq %0d, want %0d", m_tdata[30:0], e.seq));
                if (m_tdata[62:31] !== e.sum)
                    report($sformatf("sum %h, want %h", m_tdata[62:31], e.sum));
                if (m_tdata[222:63] !== e.pay)
                    report($sformatf("payload %h, want %h", m_tdata[222:63], e.pay));
                if (m_tlast !== e.last)
                    report($sformatf("last %0b, want %0b", m_tlast, e.last));
            end
        end
    end

    // result-side stalls
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    dir_row_t dir_rows [$];

    initial begin
        int n;
        logic [31:0] bs;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0;
        m_tready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        quiet_cycles = 0; idle_on = 1;
        n_errors = 0; n_items = 0; n_pkts = 0; n_refused = 0; n_resent = 0;
        g_now = 0; g_base = 0; g_next = 0; g_tail = 32'hFFFF_FFFF; g_trun = 0;
        g_tleft = 0; g_bslot = 0; g_win = 6'd8; g_tmo = 16'd100;

        // directed rows, from reset: window 8, timeout 100
        dir_rows = '{
            '{FUNC_TICK, '0, 0, 0, 0, 0, 0},                              // timer idle
            '{FUNC_ACK, '0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0},       // dup ack at reset
            '{FUNC_MSG, {160{1'b1}}, 0, 0, 0, 0, 1},
            '{FUNC_MSG, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1},
            '{FUNC_MSG, {20{8'h80}}, 0, 0, 0, 0, 1},
            '{FUNC_MSG, {20{8'h7F}}, 0, 0, 0, 0, 1},
            '{FUNC_NONE, {160{1'b1}}, 0, 0, 0, 0, 0},                     // unused func
            '{FUNC_ACK, {20{8'h11}}, 5, 1, 32'h8000_0000, 0, 0},          // corrupt
            '{FUNC_ACK, '0, 7, 100, 0, 1, 0},                             // out of range
            '{FUNC_ACK, {20{8'hFE}}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0},
            '{FUNC_ACK, {20{8'h01}}, 3, 0, 0, 1, 0},                      // base to 1
            '{FUNC_ACK, '0, 3, 0, 0, 1, 0},                               // duplicate
            '{FUNC_TICK, '0, 0, 0, 0, 0, 0},
            '{FUNC_ACK, {20{8'hC3}}, 9, 3, 0, 1, 0},                      // all acked
            '{FUNC_MSG, 160'h0102_0304_0500_0708_090A, 0, 0, 0, 0, 1},   // zero mid-payload
            '{FUNC_MSG, 160'h80, 0, 0, 0, 0, 1},
            '{FUNC_ACK, {20{8'h7F}}, 32'h7FFF_FFFF, 4, 0, 1, 0}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            dir_row_t row;
            row = dir_rows[i];
            if (row.good_sum) begin
                void'(trim_bytes(row.pay, bs));
                row.asum = row.aseq + row.anum + bs;
            end
            send_item(row.func, row.pay, row.aseq, row.anum, row.asum, n);
            if (row.n_out >= 0 && n != row.n_out)
                report($sformatf("row %0d: %0d results predicted, table says %0d",
                                 i, n, row.n_out));
        end

        // fast timeout, full window
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_WINDOW, 16'd32);
        random_traffic(40, 40);
        // window 1, timeouts of a few ticks
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd3);
        random_traffic(40, 35);
        // fill the buffer until messages are refused, then retransmit and clear it
        write_reg(CFG_WINDOW, 16'd63);
        write_reg(CFG_TIMEOUT, 16'd65535);
        for (int i = 0; i < 70; i++)
            send_item(FUNC_MSG, rand_payload(), $urandom(), $urandom(), $urandom(), n);
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(FUNC_TICK, '0, 0, 0, 0, n);
        while (g_base != g_next) send_ack({1'b0, g_next} - 32'd1, 0, n);
        // mid-range settings
        write_reg(CFG_WINDOW, 16'd5);
        write_reg(CFG_TIMEOUT, 16'd6);
        random_traffic(60, 40);
        // last part without idling
        write_reg(CFG_WINDOW, 16'd1);
        write_reg(CFG_TIMEOUT, 16'd2);
        idle_on = 0;
        random_traffic(45, 40);

        drain_out();
        $display("%0d items driven, %0d results checked (%0d refusals, %0d resent packets)",
                 n_items, n_pkts, n_refused, n_resent);
        $display("windows 0..63 and timeouts 0..65535 exercised, buffer-full case included");
        if (n_errors == 0 && pending_pkts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
